// ----- rtl/gbtk_pkg.sv -----
`timescale 1ns / 1ps

package gbtk_pkg;

  localparam int unsigned ScoreW      = 16;
  localparam int unsigned IdW         = 20;
  localparam int unsigned SlotOutW    = 4;
  localparam int unsigned TableSlotsDef = 16;

endpackage

// ----- rtl/group_best_top_k_tracker.sv -----
`timescale 1ns / 1ps

// Group best top-K tracker.
// Input channel (in_valid_i / in_ready_o) carries candidates and read-out
// requests; output channel (out_valid_o / out_ready_i) carries results.
// op_i = 0: candidate. The group's best (score, id) is folded in on the
// transfer cycle; a candidate without end_of_group_i gives no result and the
// block is ready again in the next cycle. With end_of_group_i the group best
// is offered to a ranked table of TableSlots entries held in one memory,
// walked one entry at a time: each visited entry is read, then compared and
// moved; then the insert, if any, is written and the result is loaded.
// op_i = 1: read-out, one result per used slot in ascending score order;
// an empty table gives one all-zero result with last_item_o set.
// The block takes one item at a time: in_ready_o is low while an offer or a
// read-out is in progress. A stalled receiver holds the result in the output
// register and the sequencer waits before loading the next one.
// Reset empties the table and closes any open group; the table memory itself
// is not cleared, since only entries below the fill count are ever read.
module group_best_top_k_tracker #(
  parameter int unsigned TableSlots = gbtk_pkg::TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [gbtk_pkg::ScoreW-1:0]   cand_score_i,
  input  logic [gbtk_pkg::IdW-1:0]      cand_id_i,
  input  logic                          end_of_group_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          entry_valid_o,
  output logic                          accepted_o,
  output logic [gbtk_pkg::SlotOutW-1:0] slot_index_o,
  output logic [gbtk_pkg::IdW-1:0]      win_id_o,
  output logic [gbtk_pkg::ScoreW-1:0]   win_score_o,
  output logic                          last_item_o
);
  import gbtk_pkg::*;

  localparam int unsigned IdxW  = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CntW  = $clog2(TableSlots + 1);
  localparam int unsigned WordW = IdxW + ScoreW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSlots - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TableSlots);

  typedef enum logic [2:0] {
    StIdle, StOffRd, StOffCmp, StIns, StEmit, StRoRd, StRoEmit
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      fill_q;
  logic [IdxW-1:0]      r_q;
  logic [IdxW-1:0]      ins_pos_q;
  logic [IdxW-1:0]      slot_q;
  logic                 full_mode_q;
  logic                 acc_q;
  logic [ScoreW-1:0]    score_q;
  logic [IdW-1:0]       id_q;
  logic                 in_group_q;
  logic [ScoreW-1:0]    gbest_score_q;
  logic [IdW-1:0]       gbest_id_q;

  logic                 out_valid_q;
  logic                 entry_valid_q;
  logic                 accepted_q;
  logic [IdxW-1:0]      slot_out_q;
  logic [IdW-1:0]       win_id_q;
  logic [ScoreW-1:0]    win_score_q;
  logic                 last_item_q;

  // ranked table: entry r holds {slot, score} of rank r, ascending
  logic [WordW-1:0]     rank_mem [TableSlots];
  logic [WordW-1:0]     rd_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_wa;
  logic [WordW-1:0]     mem_wd;

  logic [IdxW-1:0]      rd_slot;
  logic [ScoreW-1:0]    rd_score;
  logic                 new_le;
  logic                 out_free;
  logic                 out_load;
  logic                 in_fire;
  logic [ScoreW-1:0]    base_score;
  logic [IdW-1:0]       base_id;
  logic [ScoreW-1:0]    best_score;
  logic [IdW-1:0]       best_id;
  logic [IdxW+SlotOutW-1:0] slot_ext;

  assign rd_slot  = rd_q[WordW-1:ScoreW];
  assign rd_score = rd_q[ScoreW-1:0];
  assign new_le   = (score_q <= rd_score);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && (state_q inside {StEmit, StRoEmit});

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    base_score = in_group_q ? gbest_score_q : '0;
    base_id    = in_group_q ? gbest_id_q : cand_id_i;
    if (cand_score_i > base_score) begin
      best_score = cand_score_i;
      best_id    = cand_id_i;
    end else begin
      best_score = base_score;
      best_id    = base_id;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_q;
    case (state_q)
      StOffCmp: begin
        if (full_mode_q) begin
          // shift a smaller entry down over the evicted minimum
          if (r_q != '0 && !new_le) begin
            mem_we = 1'b1;
            mem_wa = r_q - 1'b1;
          end
        end else if (new_le) begin
          // shift a larger-or-equal entry up to make room
          mem_we = 1'b1;
          mem_wa = r_q + 1'b1;
        end
      end
      StIns: begin
        mem_we = 1'b1;
        mem_wa = ins_pos_q;
        mem_wd = {slot_q, score_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rank_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rank_mem[r_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      fill_q        <= '0;
      r_q           <= '0;
      ins_pos_q     <= '0;
      slot_q        <= '0;
      full_mode_q   <= 1'b0;
      acc_q         <= 1'b0;
      score_q       <= '0;
      id_q          <= '0;
      in_group_q    <= 1'b0;
      gbest_score_q <= '0;
      gbest_id_q    <= '0;
      out_valid_q   <= 1'b0;
      entry_valid_q <= 1'b0;
      accepted_q    <= 1'b0;
      slot_out_q    <= '0;
      win_id_q      <= '0;
      win_score_q   <= '0;
      last_item_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            r_q <= '0;
            if (op_i) begin
              if (fill_q == '0) begin
                acc_q   <= 1'b0;
                score_q <= '0;
                id_q    <= '0;
                state_q <= StEmit;
              end else begin
                state_q <= StRoRd;
              end
            end else begin
              gbest_score_q <= best_score;
              gbest_id_q    <= best_id;
              in_group_q    <= !end_of_group_i;
              if (end_of_group_i) begin
                score_q <= best_score;
                id_q    <= best_id;
                acc_q   <= 1'b1;
                if (fill_q == '0) begin
                  slot_q    <= '0;
                  ins_pos_q <= '0;
                  fill_q    <= fill_q + 1'b1;
                  state_q   <= StIns;
                end else if (fill_q == FullCnt) begin
                  full_mode_q <= 1'b1;
                  state_q     <= StOffRd;
                end else begin
                  full_mode_q <= 1'b0;
                  r_q         <= IdxW'(fill_q - 1'b1);
                  slot_q      <= IdxW'(fill_q);
                  fill_q      <= fill_q + 1'b1;
                  state_q     <= StOffRd;
                end
              end
            end
          end
        end
        StOffRd: begin
          state_q <= StOffCmp;
        end
        StOffCmp: begin
          if (full_mode_q) begin
            if (new_le) begin
              if (r_q == '0) begin
                // not above the minimum: reject
                acc_q   <= 1'b0;
                state_q <= StEmit;
              end else begin
                ins_pos_q <= r_q - 1'b1;
                state_q   <= StIns;
              end
            end else begin
              if (r_q == '0) begin
                slot_q <= rd_slot;
              end
              if (r_q == LastIdx) begin
                ins_pos_q <= r_q;
                state_q   <= StIns;
              end else begin
                r_q     <= r_q + 1'b1;
                state_q <= StOffRd;
              end
            end
          end else begin
            if (new_le) begin
              if (r_q == '0) begin
                ins_pos_q <= '0;
                state_q   <= StIns;
              end else begin
                r_q     <= r_q - 1'b1;
                state_q <= StOffRd;
              end
            end else begin
              ins_pos_q <= r_q + 1'b1;
              state_q   <= StIns;
            end
          end
        end
        StIns: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            entry_valid_q <= acc_q;
            accepted_q    <= acc_q;
            slot_out_q    <= acc_q ? slot_q : '0;
            win_id_q      <= id_q;
            win_score_q   <= score_q;
            last_item_q   <= 1'b1;
            state_q       <= StIdle;
          end
        end
        StRoRd: begin
          state_q <= StRoEmit;
        end
        StRoEmit: begin
          if (out_free) begin
            entry_valid_q <= 1'b1;
            accepted_q    <= 1'b0;
            slot_out_q    <= rd_slot;
            win_id_q      <= '0;
            win_score_q   <= rd_score;
            last_item_q   <= (r_q == IdxW'(fill_q - 1'b1));
            if (r_q == IdxW'(fill_q - 1'b1)) begin
              state_q <= StIdle;
            end else begin
              r_q     <= r_q + 1'b1;
              state_q <= StRoRd;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign slot_ext      = {{SlotOutW{1'b0}}, slot_out_q};
  assign out_valid_o   = out_valid_q;
  assign entry_valid_o = entry_valid_q;
  assign accepted_o    = accepted_q;
  assign slot_index_o  = slot_ext[SlotOutW-1:0];
  assign win_id_o      = win_id_q;
  assign win_score_o   = win_score_q;
  assign last_item_o   = last_item_q;

endmodule
